// ===== rtl/dlr_pkg.sv =====
// Shared constants, codes and interface types of the dense layer unit.
`default_nettype none

package dlr_pkg;

   localparam int MAX_INPUTS  = 1024;
   localparam int MAX_NEURONS = 32;
   localparam int WORD_BITS   = 16;

   localparam int OP_W        = 2;
   localparam int ROW_W       = $clog2(MAX_INPUTS);
   localparam int NEURON_W    = $clog2(MAX_NEURONS);
   localparam int COUNT_W     = $clog2(MAX_INPUTS) + 1;
   localparam int NUSED_W     = $clog2(MAX_NEURONS) + 1;
   localparam int FRAC_W      = $clog2(WORD_BITS);
   localparam int PROD_W      = 2 * WORD_BITS;
   localparam int WADDR_W     = ROW_W + NEURON_W;
   localparam int WEIGHT_DEPTH = MAX_INPUTS * MAX_NEURONS;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAC_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEURONS_USED = 2'd2;

   localparam logic [FRAC_W-1:0]  FRAC_RESET  = FRAC_W'(8);
   localparam logic [NUSED_W-1:0] NUSED_RESET = NUSED_W'(MAX_NEURONS);

   typedef enum logic [OP_W-1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_DATA   = 2'd2,
      OP_NONE   = 2'd3
   } dlr_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_LOAD
   } dlr_state_type;

   typedef struct packed {
      logic                accept;
      logic                mac_issue;
      logic                count_inc;
      logic                count_clear;
      logic                emit_load;
      logic                emit_final;
      logic [NEURON_W-1:0] neuron;
   } dlr_cmd_type;

   typedef struct packed {
      logic                count_full;
      logic                pipe_busy;
      logic                out_free;
      logic [NEURON_W-1:0] last_neuron;
   } dlr_status_type;

endpackage

`default_nettype wire

// ===== rtl/dense_layer_relu_fixed16_unit.sv =====
// Top level of the dense layer unit: one fully connected layer with optional ReLU.
//
// The request channel (req_valid, req_stall, payload req_*) carries one transaction
// per item: a weight load (row, column), a bias load (column) or one element of the
// input vector. A transaction is taken at a clock edge where req_valid is high and
// req_stall is low; weight and bias loads are written when accepted. An input element
// is accepted, then the single shared multiply-accumulate issues the 32 neurons in
// turn (one neuron per cycle), then its pipeline drains. Elements past the 1024th of
// a vector only count toward the end marker. After the element marked last, the unit
// streams neurons 0 to neurons_used-1 (clamped to 0..31) on the response channel
// (rsp_valid, rsp_stall, payload rsp_*), each through a read and a load state while
// the receiver takes them; rsp_final_res flags the last one. The result register
// holds its transaction while rsp_stall is high, and emission pauses behind it.
// The request side is stalled during the multiply-accumulate and emission phases.
// The csr_* channel writes frac_bits, relu_enable and neurons_used; csr_ready is
// always high, and writes are expected only while the unit is idle.
// A synchronous reset returns the controller to idle, empties the result register,
// clears the element count and restores the register defaults; the weight and bias
// stores keep whatever they held and must be loaded before use.
`default_nettype none

module dense_layer_relu_fixed16_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [dlr_pkg::OP_W-1:0]             req_op,
   input  wire logic [dlr_pkg::ROW_W-1:0]            req_row,
   input  wire logic [dlr_pkg::NEURON_W-1:0]         req_column,
   input  wire logic signed [dlr_pkg::WORD_BITS-1:0] req_value,
   input  wire logic                                 req_last,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [dlr_pkg::NEURON_W-1:0]              rsp_neuron,
   output logic signed [dlr_pkg::WORD_BITS-1:0]      rsp_activation,
   output logic                                      rsp_final_res,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dlr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [dlr_pkg::CSR_DATA_W-1:0]       csr_data
);
   import dlr_pkg::*;

   dlr_cmd_type    cmd;
   dlr_status_type status;

   // Writes are always taken; the user alone keeps them to when the unit is idle.
   assign csr_ready = 1'b1;

   dlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_last  (req_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dlr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_value      (req_value),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_neuron     (rsp_neuron),
      .rsp_activation (rsp_activation),
      .rsp_final_res  (rsp_final_res)
   );

endmodule

`default_nettype wire

// ===== rtl/dlr_datapath.sv =====
// Datapath of the dense layer unit: stores, shared multiply-accumulate and result register.
`default_nettype none

module dlr_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dlr_pkg::dlr_cmd_type              cmd,
   output dlr_pkg::dlr_status_type                status,
   input  wire logic [dlr_pkg::OP_W-1:0]          req_op,
   input  wire logic [dlr_pkg::ROW_W-1:0]         req_row,
   input  wire logic [dlr_pkg::NEURON_W-1:0]      req_column,
   input  wire logic signed [dlr_pkg::WORD_BITS-1:0] req_value,
   input  wire logic                              csr_write,
   input  wire logic [dlr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dlr_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic [dlr_pkg::NEURON_W-1:0]           rsp_neuron,
   output logic signed [dlr_pkg::WORD_BITS-1:0]   rsp_activation,
   output logic                                   rsp_final_res
);
   import dlr_pkg::*;

   // Configuration.
   logic [FRAC_W-1:0]  frac_ff;
   logic               relu_ff;
   logic [NUSED_W-1:0] nused_ff;

   // Element counter.
   logic [COUNT_W-1:0] count_ff, count_in;

   // Stores.
   logic signed [WORD_BITS-1:0] weight_mem_ff [0:WEIGHT_DEPTH-1];
   logic signed [WORD_BITS-1:0] bias_mem_ff   [0:MAX_NEURONS-1];
   logic signed [WORD_BITS-1:0] acc_mem_ff    [0:MAX_NEURONS-1];
   logic signed [WORD_BITS-1:0] weight_rd_ff, bias_rd_ff, acc_rd_ff;

   // Pipeline.
   logic signed [WORD_BITS-1:0] x_ff;
   logic                        s1_valid_ff, s2_valid_ff;
   logic [NEURON_W-1:0]         s1_neuron_ff, s2_neuron_ff;
   logic                        s1_first_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [WORD_BITS-1:0] base_ff;
   logic signed [PROD_W-1:0]    term_full;
   logic signed [WORD_BITS-1:0] acc_sum;
   logic [WADDR_W-1:0]          weight_waddr, weight_raddr;

   // Result register.
   logic                        rsp_valid_ff;
   logic [NEURON_W-1:0]         rsp_neuron_ff;
   logic signed [WORD_BITS-1:0] rsp_act_ff, act_in;
   logic                        rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff  <= FRAC_RESET;
         relu_ff  <= 1'b1;
         nused_ff <= NUSED_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAC_BITS:    frac_ff  <= csr_data[FRAC_W-1:0];
            CSR_RELU_ENABLE:  relu_ff  <= csr_data[0];
            CSR_NEURONS_USED: nused_ff <= csr_data[NUSED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign weight_waddr = {req_row, req_column};
   assign weight_raddr = {count_ff[ROW_W-1:0], cmd.neuron};

   // Loads are written in the cycle the transaction is accepted.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_WEIGHT) begin
         weight_mem_ff[weight_waddr] <= req_value;
      end
      weight_rd_ff <= weight_mem_ff[weight_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_BIAS) begin
         bias_mem_ff[req_column] <= req_value;
      end
      bias_rd_ff <= bias_mem_ff[cmd.neuron];
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_mem_ff[s2_neuron_ff] <= acc_sum;
      end
      acc_rd_ff <= acc_mem_ff[cmd.neuron];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_DATA) begin
         x_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.mac_issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // The first element of a vector starts each sum from its bias.
   always_ff @(posedge clock) begin
      s1_neuron_ff <= cmd.neuron;
      s1_first_ff  <= (count_ff == '0);
      s2_neuron_ff <= s1_neuron_ff;
      prod_ff      <= x_ff * weight_rd_ff;
      base_ff      <= s1_first_ff ? bias_rd_ff : acc_rd_ff;
   end

   assign term_full = prod_ff >>> frac_ff;
   assign acc_sum   = base_ff + term_full[WORD_BITS-1:0];

   assign act_in = (relu_ff && acc_rd_ff[WORD_BITS-1]) ? '0 : acc_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_neuron_ff <= cmd.neuron;
         rsp_act_ff    <= act_in;
         rsp_final_ff  <= cmd.emit_final;
      end
   end

   always_comb begin
      status.count_full = (count_ff == COUNT_W'(MAX_INPUTS));
      status.pipe_busy  = s1_valid_ff || s2_valid_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      if (nused_ff == '0) begin
         status.last_neuron = '0;
      end else if (nused_ff > NUSED_W'(MAX_NEURONS)) begin
         status.last_neuron = NEURON_W'(MAX_NEURONS - 1);
      end else begin
         status.last_neuron = NEURON_W'(nused_ff - NUSED_W'(1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron     = rsp_neuron_ff;
   assign rsp_activation = rsp_act_ff;
   assign rsp_final_res  = rsp_final_ff;

endmodule

`default_nettype wire

// ===== rtl/dlr_ctrl.sv =====
// Controller state machine of the dense layer unit.
`default_nettype none

module dlr_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [dlr_pkg::OP_W-1:0]   req_op,
   input  wire logic                       req_last,
   output logic                            req_stall,
   input  wire dlr_pkg::dlr_status_type    status,
   output dlr_pkg::dlr_cmd_type            cmd
);
   import dlr_pkg::*;

   dlr_state_type       state_ff, state_in;
   logic [NEURON_W-1:0] neuron_ff, neuron_in;
   logic                last_ff, last_in;
   logic                accept;
   logic                is_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign is_data   = (req_op == OP_DATA);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         neuron_ff <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         neuron_ff <= neuron_in;
         last_ff   <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_data) begin
               if (!status.count_full) begin
                  state_in = ST_MAC;
               end else if (req_last) begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_MAC: begin
            if (neuron_ff == NEURON_W'(MAX_NEURONS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (status.out_free) begin
               state_in = (neuron_ff == status.last_neuron) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.neuron = neuron_ff;
      neuron_in = neuron_ff;
      last_in   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept) begin
               last_in   = req_last;
               neuron_in = '0;
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            neuron_in     = neuron_ff + NEURON_W'(1);
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.count_inc = 1'b1;
               neuron_in     = '0;
            end
         end
         ST_EMIT_RD: ;
         ST_EMIT_LOAD: begin
            if (status.out_free) begin
               cmd.emit_load  = 1'b1;
               cmd.emit_final = (neuron_ff == status.last_neuron);
               if (neuron_ff == status.last_neuron) begin
                  cmd.count_clear = 1'b1;
               end else begin
                  neuron_in = neuron_ff + NEURON_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/dlr_checker.sv =====
// Port-level assertions of the dense layer unit and their binding to the top level.
`default_nettype none

module dlr_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [dlr_pkg::NEURON_W-1:0]         rsp_neuron,
   input wire logic signed [dlr_pkg::WORD_BITS-1:0] rsp_activation,
   input wire logic                                 rsp_final_res
);

   // A stalled result transaction is held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_neuron)
         && $stable(rsp_activation) && $stable(rsp_final_res))
      else $error("stalled result changed");

   // Reset empties the result register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // While a non-final result is pending, emission is still running and requests wait.
   a_emit_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> req_stall)
      else $error("request side open during emission");

   // A result that follows a taken one in the next cycle belongs to another neuron.
   a_next_neuron: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid || rsp_neuron != $past(rsp_neuron))
      else $error("result repeated");

endmodule

bind dense_layer_relu_fixed16_unit dlr_checker u_dlr_checker (.*);

`default_nettype wire

// ===== bench/tb_dense_layer_relu_fixed16_unit.sv =====
// Self-checking testbench for the fixed-point dense layer unit with optional ReLU.
`timescale 1ns / 1ps

module tb_dense_layer_relu_fixed16_unit;
   import dlr_pkg::*;

   // The csr index that maps to no register; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // An input element occupies the unit through issue and drain without producing a
   // result, so this many quiet cycles guarantee the controller is back in idle.
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_PHASES = 4;
   localparam int ITEMS_PER_PHASE = 28;
   // Weight rows loaded up front; no vector runs longer than this.
   localparam int FILL_ROWS = 6;

   typedef struct {
      logic [NEURON_W-1:0]         neuron;
      logic signed [WORD_BITS-1:0] activation;
      logic                        final_res;
   } neuron_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [OP_W-1:0]             req_op = OP_NONE;
   logic [ROW_W-1:0]            req_row = '0;
   logic [NEURON_W-1:0]         req_column = '0;
   logic signed [WORD_BITS-1:0] req_value = '0;
   logic                        req_last = 1'b0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [NEURON_W-1:0]         rsp_neuron;
   logic signed [WORD_BITS-1:0] rsp_activation;
   logic                        rsp_final_res;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   // Idle and stall rates, in percent, for the sender and the receiver.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count = 0;

   // Shadow copy of the layer: stores, accumulators, element position and the
   // three configuration registers, all updated as transactions are accepted.
   logic signed [WORD_BITS-1:0] weight_mem [WEIGHT_DEPTH];
   logic signed [WORD_BITS-1:0] bias_mem [MAX_NEURONS];
   logic signed [WORD_BITS-1:0] layer_acc [MAX_NEURONS];
   int unsigned                 elem_count = 0;
   logic [FRAC_W-1:0]           cfg_frac = FRAC_RESET;
   logic                        cfg_relu = 1'b1;
   logic [NUSED_W-1:0]          cfg_nused = NUSED_RESET;

   // Neuron outputs predicted but not yet seen on the response channel, oldest first.
   neuron_result_type expected_activations [$];

   dense_layer_relu_fixed16_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_neuron     (rsp_neuron),
      .rsp_activation (rsp_activation),
      .rsp_final_res  (rsp_final_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The receiver stalls at random; the rate follows the current idling phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Every accepted response transaction is matched against the oldest prediction.
   // Sampling at the rising edge sees the values the unit itself used at that edge.
   always @(posedge clock) begin : check_results
      neuron_result_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_activations.size() == 0) begin
            report_mismatch($sformatf("unexpected result for neuron %0d", rsp_neuron));
         end else begin
            oldest = expected_activations.pop_front();
            if (rsp_neuron !== oldest.neuron)
               report_mismatch($sformatf("neuron index %0d, wanted %0d",
                                         rsp_neuron, oldest.neuron));
            if (rsp_activation !== oldest.activation)
               report_mismatch($sformatf("neuron %0d activation %0d, wanted %0d",
                                         oldest.neuron, rsp_activation, oldest.activation));
            if (rsp_final_res !== oldest.final_res)
               report_mismatch($sformatf("neuron %0d final flag %0b, wanted %0b",
                                         oldest.neuron, rsp_final_res, oldest.final_res));
         end
      end
   end

   // Applies one accepted request to the shadow layer and queues any outputs it
   // releases. Products are full 32-bit signed values; the arithmetic shift floors
   // them, and both the term and the running sum wrap at the word width.
   task automatic update_layer_model(input dlr_op_type op,
                                     input logic [ROW_W-1:0] row,
                                     input logic [NEURON_W-1:0] column,
                                     input logic signed [WORD_BITS-1:0] value,
                                     input logic last);
      logic signed [PROD_W-1:0]    product;
      logic signed [WORD_BITS-1:0] term;
      logic signed [WORD_BITS-1:0] outcome;
      int unsigned                 emit_count;
      neuron_result_type           item;
      case (op)
         OP_WEIGHT: weight_mem[{row, column}] = value;
         OP_BIAS:   bias_mem[column] = value;
         OP_DATA: begin
            // The first element of a vector reloads every accumulator from its bias.
            if (elem_count == 0) begin
               for (int n = 0; n < MAX_NEURONS; n++) layer_acc[n] = bias_mem[n];
            end
            // Elements past the end of the weight rows only move toward the marker.
            if (elem_count < MAX_INPUTS) begin
               for (int n = 0; n < MAX_NEURONS; n++) begin
                  product = value * weight_mem[{elem_count[ROW_W-1:0], NEURON_W'(n)}];
                  term = WORD_BITS'(product >>> cfg_frac);
                  layer_acc[n] = layer_acc[n] + term;
               end
               elem_count++;
            end
            if (last) begin
               // A neuron count of zero still emits one neuron; above the array
               // size it is held at the array size.
               if (cfg_nused == 0) emit_count = 1;
               else if (cfg_nused > MAX_NEURONS) emit_count = MAX_NEURONS;
               else emit_count = cfg_nused;
               for (int n = 0; n < emit_count; n++) begin
                  outcome = layer_acc[n];
                  if (cfg_relu && outcome < 0) outcome = '0;
                  item.neuron = NEURON_W'(n);
                  item.activation = outcome;
                  item.final_res = (n + 1 == emit_count);
                  expected_activations.push_back(item);
               end
               elem_count = 0;
            end
         end
         default: ;
      endcase
   endtask

   // Presents one request transaction, holding it steady until the unit takes it.
   // A random idle stretch may precede it; valid is never dropped and raised in
   // the same time step, so a back-to-back item just replaces the payload.
   task automatic send_item(input dlr_op_type op,
                            input logic [ROW_W-1:0] row,
                            input logic [NEURON_W-1:0] column,
                            input logic signed [WORD_BITS-1:0] value,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_row    <= row;
      req_column <= column;
      req_value  <= value;
      req_last   <= last;
      do @(posedge clock); while (req_stall);
      update_layer_model(op, row, column, value, last);
   endtask

   // Load requests carry a random last bit, data requests random load fields:
   // the unit must ignore both.
   task automatic load_weight(input logic [ROW_W-1:0] row, input logic [NEURON_W-1:0] column,
                              input logic signed [WORD_BITS-1:0] value);
      send_item(OP_WEIGHT, row, column, value, 1'($urandom_range(1)));
   endtask

   task automatic load_bias(input logic [NEURON_W-1:0] column,
                            input logic signed [WORD_BITS-1:0] value);
      send_item(OP_BIAS, ROW_W'($urandom), column, value, 1'($urandom_range(1)));
   endtask

   task automatic send_element(input logic signed [WORD_BITS-1:0] value, input logic last);
      send_item(OP_DATA, ROW_W'($urandom), NEURON_W'($urandom), value, last);
   endtask

   // Word values lean toward the extremes so that wrapping and clamping are hit often.
   function automatic logic signed [WORD_BITS-1:0] random_word();
      case ($urandom_range(7))
         0:       return {1'b1, {(WORD_BITS-1){1'b0}}};
         1:       return {1'b0, {(WORD_BITS-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return WORD_BITS'($urandom);
      endcase
   endfunction

   // Releases the request channel and waits until every predicted output has
   // arrived and the unit has had time to finish any element still in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_activations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; csr_valid stays high so writes can run back to back.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FRAC_BITS:    cfg_frac = data[FRAC_W-1:0];
         CSR_RELU_ENABLE:  cfg_relu = data[0];
         CSR_NEURONS_USED: cfg_nused = data[NUSED_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers while the unit is idle. Data is the raw csr
   // word, so values wider than a register exercise its masking.
   task automatic configure(input logic [CSR_DATA_W-1:0] frac,
                            input logic [CSR_DATA_W-1:0] relu,
                            input logic [CSR_DATA_W-1:0] nused);
      wait_idle();
      write_csr(CSR_FRAC_BITS, frac);
      write_csr(CSR_RELU_ENABLE, relu);
      write_csr(CSR_NEURONS_USED, nused);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Every bias and every weight of the first rows is written once; vectors stay
   // within those rows, so no element reads an entry that was never loaded.
   task automatic test_store_fill();
      for (int c = 0; c < MAX_NEURONS; c++) load_bias(NEURON_W'(c), random_word());
      for (int r = 0; r < FILL_ROWS; r++) begin
         for (int c = 0; c < MAX_NEURONS; c++)
            load_weight(ROW_W'(r), NEURON_W'(c), random_word());
      end
   endtask

   // A short vector under the register values left by reset: eight fraction
   // bits, ReLU on, all 32 neurons. 256 is one in this format.
   task automatic test_reset_defaults();
      send_element(16'sd256, 1'b0);
      send_element(-16'sd256, 1'b0);
      send_element(16'sd32767, 1'b1);
   endtask

   // Extreme words in biases, weights and data, at the first and last row and
   // column, first with no shift and no clamp, then with the widest shift and ReLU.
   task automatic test_field_extremes();
      configure(6'd0, 6'd0, 6'd32);
      load_bias(NEURON_W'(0), -16'sd32768);
      load_bias(NEURON_W'(MAX_NEURONS - 1), 16'sd32767);
      load_weight(ROW_W'(0), NEURON_W'(0), -16'sd32768);
      load_weight(ROW_W'(0), NEURON_W'(MAX_NEURONS - 1), 16'sd32767);
      load_weight(ROW_W'(1), NEURON_W'(0), 16'sd32767);
      load_weight(ROW_W'(MAX_INPUTS - 1), NEURON_W'(MAX_NEURONS - 1), -16'sd1);
      send_element(-16'sd32768, 1'b0);
      send_element(16'sd32767, 1'b1);
      // Frac bits takes the low four bits of the word; relu takes bit zero.
      configure(6'h3F, 6'h3F, 6'd32);
      send_element(-16'sd32768, 1'b1);
   endtask

   // Neuron counts of zero, one below the top, and above the array size.
   task automatic test_neuron_count();
      configure(6'd8, 6'd1, 6'd0);
      send_element(random_word(), 1'b1);
      configure(6'd8, 6'd0, 6'd33);
      send_element(random_word(), 1'b1);
      configure(6'd4, 6'd1, 6'd63);
      send_element(random_word(), 1'b1);
      configure(6'd8, 6'd0, 6'd31);
      send_element(random_word(), 1'b1);
   endtask

   // The spare csr index and the spare opcode, even one carrying a last flag,
   // must leave the layer untouched, also in the middle of a vector.
   task automatic test_unused_codes();
      wait_idle();
      write_csr(CSR_UNUSED, 6'h2A);
      csr_valid <= 1'b0;
      configure(6'd8, 6'd1, 6'd32);
      send_item(OP_NONE, ROW_W'($urandom), NEURON_W'($urandom), random_word(), 1'b1);
      send_element(random_word(), 1'b0);
      send_item(OP_NONE, ROW_W'($urandom), NEURON_W'($urandom), random_word(), 1'b1);
      send_element(random_word(), 1'b1);
   endtask

   // Random traffic cycling through four idling patterns. Most of it is
   // well-formed vectors with random content, some with loads rewriting the
   // stores mid-vector; the rest is stray loads and spare opcodes.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned vec_len;
      logic [CSR_DATA_W-1:0] nused;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(5))
            0:       nused = 6'd0;
            1:       nused = 6'd1;
            2:       nused = 6'd32;
            3:       nused = CSR_DATA_W'($urandom_range(33, 63));
            default: nused = CSR_DATA_W'($urandom_range(2, 31));
         endcase
         configure(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), nused);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            case ($urandom_range(9))
               0: send_item(OP_NONE, ROW_W'($urandom), NEURON_W'($urandom),
                            random_word(), 1'($urandom_range(1)));
               1: begin
                  load_bias(NEURON_W'($urandom), random_word());
                  sent++;
               end
               2: begin
                  load_weight(ROW_W'($urandom_range(0, 7)), NEURON_W'($urandom),
                              random_word());
                  sent++;
               end
               default: begin
                  vec_len = $urandom_range(1, FILL_ROWS);
                  for (int i = 0; i < vec_len; i++) begin
                     if ($urandom_range(9) == 0) begin
                        load_weight(ROW_W'($urandom), NEURON_W'($urandom), random_word());
                        sent++;
                     end
                     send_element(random_word(), i == vec_len - 1);
                     sent++;
                  end
               end
            endcase
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // Main sequence: reset once, fill the stores, run the directed cases, then
   // the random traffic; finally wait for the last outputs and give the verdict.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_store_fill();
      test_reset_defaults();
      test_field_extremes();
      test_neuron_count();
      test_unused_codes();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under two milliseconds of simulated time.
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
